// ===== hw/rtl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// Hash table package
// Widths, command, status and slot mark codes, and default parameters shared
// by the hash table modules.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int CMD_W      = 2;
    localparam int KEY_ID_W   = 32;
    localparam int HASH_W     = 32;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int MAX_FILL_W = 6;
    localparam int MARK_W     = 2;

    localparam int DEF_SLOTS      = 64;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 64;

    // The start slot reducer folds this many hash bits per cycle.
    localparam int HASH_DIGIT_W = 8;

    localparam logic [MAX_FILL_W-1:0] MAX_FILL_RESET = 6'd48;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [MARK_W-1:0]   t_mark;

    localparam t_cmd CMD_GET    = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;

    localparam t_status STATUS_DONE      = 2'd0;
    localparam t_status STATUS_NOT_FOUND = 2'd1;
    localparam t_status STATUS_FULL      = 2'd2;

    localparam t_mark MARK_EMPTY = 2'd0;
    localparam t_mark MARK_LIVE  = 2'd1;
    localparam t_mark MARK_TOMB  = 2'd2;

endpackage

// ===== hw/rtl/oaht_if.sv =====
// ----------------------------------------------------------------------------
// Hash table channels
// Valid/ready request and response channels of the hash table.
// ----------------------------------------------------------------------------
interface oaht_req_if
    import oaht_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [KEY_ID_W-1:0] key_id;
    logic [HASH_W-1:0]   key_hash;
    logic [VALUE_W-1:0]  value_in;

    modport source (output valid, command, key_id, key_hash, value_in, input ready);
    modport sink   (input valid, command, key_id, key_hash, value_in, output ready);
endinterface

interface oaht_rsp_if
    import oaht_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                is_new;
    logic [VALUE_W-1:0]  value_out;

    modport source (output valid, status, is_new, value_out, input ready);
    modport sink   (input valid, status, is_new, value_out, output ready);
endinterface

// ===== hw/rtl/oaht_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram
    import oaht_pkg::*;
#(
    parameter int  WIDTH = DEF_VALUE_BITS,
    parameter int  DEPTH = DEF_SLOTS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/oaht_start_slot.sv =====
// ----------------------------------------------------------------------------
// Start slot reducer
// Reduces a key hash modulo the slot count. A power-of-two table takes the
// low bits; any other size folds eight hash bits per cycle.
// ----------------------------------------------------------------------------
module oaht_start_slot
    import oaht_pkg::*;
#(
    parameter int  SLOTS = DEF_SLOTS,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_hash,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_slot
);

    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic             r_done;
            logic [IDX_W-1:0] r_slot;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                    if (i_start) begin
                        r_slot <= i_hash[IDX_W-1:0];
                    end
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end else begin : g_fold
            localparam int ROUNDS = HASH_W / HASH_DIGIT_W;
            localparam int CNT_W  = $clog2(ROUNDS);
            localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(SLOTS);

            logic              r_busy;
            logic              r_done;
            logic [CNT_W-1:0]  r_cnt;
            logic [IDX_W-1:0]  r_rem;
            logic [HASH_W-1:0] r_hash;
            logic [IDX_W:0]    w_trial;
            logic [IDX_W-1:0]  n_rem;

            // Shift in one hash bit at a time; the remainder stays below
            // SLOTS, so one conditional subtract per bit is enough.
            always_comb begin
                n_rem   = r_rem;
                w_trial = '0;
                for (int b = 0; b < HASH_DIGIT_W; b++) begin
                    w_trial = {n_rem, r_hash[HASH_W-1-b]};
                    if (w_trial >= MODULUS) begin
                        w_trial = w_trial - MODULUS;
                    end
                    n_rem = w_trial[IDX_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                        r_rem  <= '0;
                        r_hash <= i_hash;
                    end else if (r_busy) begin
                        r_rem  <= n_rem;
                        r_hash <= r_hash << HASH_DIGIT_W;
                        r_cnt  <= r_cnt + 1'b1;
                        if (r_cnt == CNT_W'(ROUNDS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            assign o_done = r_done;
            assign o_slot = r_rem;
        end
    endgenerate

endmodule

// ===== hw/rtl/open_addressing_hash_table.sv =====
// ----------------------------------------------------------------------------
// Open addressing hash table
// Key/value table with linear probing and tombstones, held in a slot RAM
// (mark and key) and a value RAM.
//
//   Channel  Dir  Handshake          Contents
//   i_req    in   valid/ready        command, key_id, key_hash, value_in
//   o_rsp    out  valid/ready        status, is_new, value_out
//   i_cfg    in   write enable only  max_fill
//
// A request probes one slot per cycle through the pipelined read of the slot
// RAM, after the start slot reducer has reduced its hash. A table whose slot
// count is not a power of two folds the hash rather than taking its low bits.
// Get and delete on an empty table, and unused commands, skip the hash and
// probe. After reset the slot marks are cleared one slot at a time; no request
// is taken meanwhile. One response waits in the output register while the next
// request is accepted; a second finished response waits until it drains.
// ----------------------------------------------------------------------------
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    oaht_req_if.sink              i_req,
    oaht_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [MAX_FILL_W-1:0] i_cfg_wdata
);

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int FILL_W   = $clog2(SLOTS + 1);
    localparam int CMP_W    = (FILL_W > MAX_FILL_W) ? FILL_W : MAX_FILL_W;
    localparam int KEY_IN_W = (KEY_BITS < KEY_ID_W) ? KEY_BITS : KEY_ID_W;
    localparam int SLOT_W   = KEY_BITS + MARK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_cnt, n_cnt;
    logic                  r_have_tomb, n_have_tomb;
    logic [IDX_W-1:0]      r_tomb_idx, n_tomb_idx;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [MAX_FILL_W-1:0] r_max_fill;
    t_status               r_res_status, n_res_status;
    logic                  r_res_is_new, n_res_is_new;
    logic [VALUE_BITS-1:0] r_res_value, n_res_value;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic                  r_out_is_new;
    logic [VALUE_BITS-1:0] r_out_value;

    logic                  slot_we;
    logic [IDX_W-1:0]      slot_waddr;
    logic [SLOT_W-1:0]     slot_wdata;
    logic [SLOT_W-1:0]     slot_rdata;
    logic                  val_we;
    logic [IDX_W-1:0]      val_waddr;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [IDX_W-1:0]      rd_addr;
    logic                  ss_start;
    logic                  ss_done;
    logic [IDX_W-1:0]      ss_slot;

    logic [IDX_W-1:0]      idx_next;
    t_mark                 rd_mark;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  probe_hit;
    logic                  probe_empty;
    logic                  tomb_seen;
    logic [IDX_W-1:0]      tomb_at;
    logic                  fill_limit;
    logic                  req_fire;
    logic                  out_load;

    oaht_start_slot #(
        .SLOTS (SLOTS)
    ) u_start_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ss_start),
        .i_hash  (i_req.key_hash),
        .o_done  (ss_done),
        .o_slot  (ss_slot)
    );

    oaht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (rd_addr),
        .o_rdata (slot_rdata)
    );

    oaht_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_value),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    assign idx_next    = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign rd_mark     = slot_rdata[KEY_BITS +: MARK_W];
    assign rd_key      = slot_rdata[KEY_BITS-1:0];
    assign probe_hit   = (rd_mark == MARK_LIVE) && (rd_key == r_key);
    assign probe_empty = (rd_mark == MARK_EMPTY);
    // Any mark that is neither empty nor live counts as a tombstone.
    assign tomb_seen   = r_have_tomb || (!probe_empty && (rd_mark != MARK_LIVE));
    assign tomb_at     = r_have_tomb ? r_tomb_idx : r_idx;
    assign fill_limit  = CMP_W'(r_fill) >= CMP_W'(r_max_fill);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.is_new    = r_out_is_new;
    assign o_rsp.value_out = VALUE_W'(r_out_value);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_value      = r_value;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_have_tomb  = r_have_tomb;
        n_tomb_idx   = r_tomb_idx;
        n_fill       = r_fill;
        n_res_status = r_res_status;
        n_res_is_new = r_res_is_new;
        n_res_value  = r_res_value;
        slot_we      = 1'b0;
        slot_waddr   = r_idx;
        slot_wdata   = {MARK_EMPTY, KEY_BITS'(0)};
        val_we       = 1'b0;
        val_waddr    = r_idx;
        rd_addr      = idx_next;
        ss_start     = 1'b0;

        case (r_state)
            S_CLEAR: begin
                slot_we = 1'b1;
                n_idx   = idx_next;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_cmd        = i_req.command;
                    n_key        = KEY_BITS'(i_req.key_id[KEY_IN_W-1:0]);
                    n_value      = i_req.value_in[VALUE_BITS-1:0];
                    n_res_status = STATUS_NOT_FOUND;
                    n_res_is_new = 1'b0;
                    n_res_value  = '0;
                    if ((i_req.command == CMD_INSERT) ||
                        (((i_req.command == CMD_GET) || (i_req.command == CMD_DELETE)) &&
                         (r_fill != '0))) begin
                        ss_start = 1'b1;
                        n_state  = S_HASH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_HASH: begin
                rd_addr = ss_slot;
                if (ss_done) begin
                    n_idx       = ss_slot;
                    n_cnt       = '0;
                    n_have_tomb = 1'b0;
                    n_state     = S_PROBE;
                end
            end
            S_PROBE: begin
                if (probe_hit) begin
                    n_state      = S_DONE;
                    n_res_status = STATUS_DONE;
                    case (r_cmd)
                        CMD_GET: begin
                            n_res_value = val_rdata;
                        end
                        CMD_INSERT: begin
                            val_we = 1'b1;
                        end
                        CMD_DELETE: begin
                            slot_we    = 1'b1;
                            slot_wdata = {MARK_TOMB, r_key};
                        end
                        default: begin
                        end
                    endcase
                end else if (probe_empty || (r_cnt == LAST_IDX)) begin
                    n_state = S_DONE;
                    if (r_cmd == CMD_INSERT) begin
                        if (fill_limit) begin
                            n_res_status = STATUS_FULL;
                        end else if (tomb_seen) begin
                            // Reuse the first tombstone; the fill count holds.
                            slot_we      = 1'b1;
                            slot_waddr   = tomb_at;
                            slot_wdata   = {MARK_LIVE, r_key};
                            val_we       = 1'b1;
                            val_waddr    = tomb_at;
                            n_res_status = STATUS_DONE;
                            n_res_is_new = 1'b1;
                        end else if (probe_empty) begin
                            slot_we      = 1'b1;
                            slot_wdata   = {MARK_LIVE, r_key};
                            val_we       = 1'b1;
                            n_fill       = r_fill + 1'b1;
                            n_res_status = STATUS_DONE;
                            n_res_is_new = 1'b1;
                        end else begin
                            n_res_status = STATUS_FULL;
                        end
                    end
                end else begin
                    n_idx       = idx_next;
                    n_cnt       = r_cnt + 1'b1;
                    n_have_tomb = tomb_seen;
                    n_tomb_idx  = tomb_at;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_have_tomb <= 1'b0;
            r_fill      <= '0;
            r_max_fill  <= MAX_FILL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cmd        <= n_cmd;
            r_key        <= n_key;
            r_value      <= n_value;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_have_tomb  <= n_have_tomb;
            r_tomb_idx   <= n_tomb_idx;
            r_fill       <= n_fill;
            r_res_status <= n_res_status;
            r_res_is_new <= n_res_is_new;
            r_res_value  <= n_res_value;
            if (i_cfg_we) begin
                r_max_fill <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_is_new <= r_res_is_new;
                r_out_value  <= r_res_value;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_only_on_probe: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PROBE) |=> $stable(r_fill)
    ) else $error("fill count changed outside a probe");

    a_out_only_from_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && (r_state != S_DONE)) |=> !r_out_valid
    ) else $error("response appeared without a finished request");

    a_accept_starts_work: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE)
    ) else $error("accepted request did not start");
`endif

endmodule
